@@ rtl/pgcs_pkg.sv @@
// pgcs_pkg: shared types and constants of the pps/gps clock sync supervisor
// holds request/response payloads, controller/datapath command and status structs
// no dependencies

package pgcs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PPS_OFFSET = 2'd1;

   localparam logic [4:0]  WINDOW_LENGTH_RESET  = 5'd10;
   localparam logic [19:0] MAX_PPS_OFFSET_RESET = 20'd50;

   typedef enum logic [1:0] {
      PH_WAIT_PPS = 2'd0,
      PH_SETTLE   = 2'd1,
      PH_SET_TIME = 2'd2,
      PH_MONITOR  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      RPT_NONE          = 4'd0,
      RPT_ACQUIRING     = 4'd1,
      RPT_ACQUIRED      = 4'd2,
      RPT_DISCIPLINING  = 4'd3,
      RPT_DISCIPLINED   = 4'd4,
      RPT_SYNCHRONIZING = 4'd5,
      RPT_ADJUSTING     = 4'd6,
      RPT_SYNCED        = 4'd7,
      RPT_MONITORING    = 4'd8
   } report_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD_I,
      ST_GET_I,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_VERDICT,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic               command;
      logic               fix_valid_time;
      logic               fix_valid_date;
      logic               fix_valid_pos;
      logic signed [31:0] gps_offset;
      logic               status_ok;
      logic               pps_present;
      logic signed [31:0] pps_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]         sync_state;
      logic [3:0]         report;
      logic               reset_pps_measure;
      logic               reset_pps_limits;
      logic               adjust_valid;
      logic signed [31:0] adjust_seconds;
      logic               sync_done;
      logic [4:0]         samples_held;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       push;
      logic       clear_win;
      logic       init_search;
      logic       get_i;
      logic       scan;
      logic       upd;
      logic       load_rsp;
      phase_type  phase;
      report_type report;
      logic       meas;
      logic       lim;
      logic       adj;
      logic       done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic command;
      logic sample_ok;
      logic status_ok;
      logic pps_present;
      logic pps_below;
      logic win_full;
      logic win_empty;
      logic scan_last;
      logic outer_last;
      logic best_zero;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ rtl/pgcs_dp.sv @@
// pgcs_dp: datapath with config registers, offset window memory, mode search
// and the response register
// depends on pgcs_pkg

module pgcs_dp #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pgcs_pkg::req_type                  req_data,
   input  logic                               csr_write,
   input  logic [pgcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pgcs_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output pgcs_pkg::rsp_type                  rsp_data,
   input  pgcs_pkg::ctrl_cmd_type             cmd,
   output pgcs_pkg::dp_status_type            status
);
   import pgcs_pkg::*;

   localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FILL_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = FILL_W + 1;

   function automatic logic [IDX_W-1:0] wrap_pos(input logic [IDX_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(MAX_SAMPLES)) begin
         s = s - SUM_W'(MAX_SAMPLES);
      end
      return s[IDX_W-1:0];
   endfunction

   req_type            req_ff;
   logic [4:0]         window_length_ff;
   logic [19:0]        max_pps_offset_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]  eff_len;

   logic signed [31:0] win_mem [MAX_SAMPLES];
   logic [IDX_W-1:0]   rd_addr;
   logic signed [31:0] rd_data_ff;

   logic [IDX_W-1:0]   push_head1, push_head2, push_slot;
   logic [FILL_W-1:0]  push_fill1, push_fill2;

   logic [IDX_W-1:0]   i_ff, j_ff;
   logic signed [31:0] cur_val_ff, best_ff;
   logic [FILL_W-1:0]  cnt_ff, best_cnt_ff;
   logic               cmp_vld_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic signed [32:0] pps_ext, lim_ext;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_LENGTH_RESET;
         max_pps_offset_ff <= MAX_PPS_OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:  window_length_ff  <= csr_data[4:0];
            CSR_MAX_PPS_OFFSET: max_pps_offset_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      if (32'(window_length_ff) > 32'(MAX_SAMPLES)) begin
         eff_len = FILL_W'(MAX_SAMPLES);
      end else begin
         eff_len = FILL_W'(window_length_ff);
      end
   end

   // push: drop oldest when full, write, then trim to the wanted length
   always_comb begin
      push_head1 = head_ff;
      push_fill1 = fill_ff;
      if (fill_ff >= FILL_W'(MAX_SAMPLES)) begin
         push_head1 = wrap_pos(head_ff, FILL_W'(1));
         push_fill1 = fill_ff - FILL_W'(1);
      end
      push_slot  = wrap_pos(push_head1, push_fill1);
      push_fill2 = push_fill1 + FILL_W'(1);
      push_head2 = push_head1;
      if (push_fill2 > eff_len) begin
         push_head2 = wrap_pos(push_head1, FILL_W'(1));
         push_fill2 = push_fill2 - FILL_W'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      if (cmd.clear_win) begin
         fill_in = '0;
         head_in = '0;
      end else if (cmd.push) begin
         fill_in = push_fill2;
         head_in = push_head2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         head_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         head_ff <= head_in;
      end
   end

   // window memory
   assign rd_addr = wrap_pos(head_ff, FILL_W'(cmd.scan ? j_ff : i_ff));

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         win_mem[push_slot] <= req_ff.gps_offset;
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   // mode search
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_search) begin
         i_ff        <= '0;
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end
      if (cmd.get_i) begin
         cur_val_ff <= rd_data_ff;
         j_ff       <= '0;
         cnt_ff     <= '0;
      end else if (cmp_vld_ff && (rd_data_ff == cur_val_ff)) begin
         cnt_ff <= cnt_ff + FILL_W'(1);
      end
      if (cmd.scan) begin
         j_ff <= IDX_W'(j_ff + IDX_W'(1));
      end
      if (cmd.upd) begin
         if ((cnt_ff > best_cnt_ff) || ((cnt_ff == best_cnt_ff) && (cur_val_ff < best_ff)))
         begin
            best_ff     <= cur_val_ff;
            best_cnt_ff <= cnt_ff;
         end
         i_ff <= IDX_W'(i_ff + IDX_W'(1));
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.sync_state        <= cmd.phase;
         rsp_ff.report            <= cmd.report;
         rsp_ff.reset_pps_measure <= cmd.meas;
         rsp_ff.reset_pps_limits  <= cmd.lim;
         rsp_ff.adjust_valid      <= cmd.adj;
         rsp_ff.adjust_seconds    <= cmd.adj ? best_ff : 32'sd0;
         rsp_ff.sync_done         <= cmd.done;
         rsp_ff.samples_held      <= 5'(fill_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status
   assign pps_ext = 33'(req_ff.pps_offset);
   assign lim_ext = $signed({13'b0, max_pps_offset_ff});

   always_comb begin
      status.command     = req_ff.command;
      status.sample_ok   = req_ff.fix_valid_time & req_ff.fix_valid_date & req_ff.fix_valid_pos;
      status.status_ok   = req_ff.status_ok;
      status.pps_present = req_ff.pps_present;
      status.pps_below   = pps_ext < lim_ext;
      status.win_full    = fill_ff == eff_len;
      status.win_empty   = fill_ff == '0;
      status.scan_last   = (FILL_W'(j_ff) + FILL_W'(1)) == fill_ff;
      status.outer_last  = (FILL_W'(i_ff) + FILL_W'(1)) == fill_ff;
      status.best_zero   = best_ff == 32'sd0;
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_SAMPLES))
      else $error("window fill beyond capacity");

   a_no_push_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.clear_win))
      else $error("push and clear in one cycle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   a_adjust_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && cmd.adj) |=> (rsp_ff.samples_held == 5'd0))
      else $error("adjustment left samples in window");
`endif

endmodule

@@ rtl/pgcs_ctrl.sv @@
// pgcs_ctrl: controller state machine, supervision phase and report decisions
// drives pgcs_dp through the command struct
// depends on pgcs_pkg

module pgcs_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pgcs_pkg::dp_status_type        status,
   output pgcs_pkg::ctrl_cmd_type         cmd
);
   import pgcs_pkg::*;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   report_type     report_ff, report_in;
   logic           meas_ff, meas_in;
   logic           lim_ff, lim_in;
   logic           adj_ff, adj_in;
   logic           done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_WAIT_PPS;
         report_ff <= RPT_NONE;
         meas_ff   <= 1'b0;
         lim_ff    <= 1'b0;
         adj_ff    <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         report_ff <= report_in;
         meas_ff   <= meas_in;
         lim_ff    <= lim_in;
         adj_ff    <= adj_in;
         done_ff   <= done_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      report_in = report_ff;
      meas_in   = meas_ff;
      lim_in    = lim_ff;
      adj_in    = adj_ff;
      done_in   = done_ff;
      req_stall = 1'b1;
      cmd        = '0;
      cmd.phase  = phase_ff;
      cmd.report = report_ff;
      cmd.meas   = meas_ff;
      cmd.lim    = lim_ff;
      cmd.adj    = adj_ff;
      cmd.done   = done_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            report_in = RPT_NONE;
            meas_in   = 1'b0;
            lim_in    = 1'b0;
            adj_in    = 1'b0;
            done_in   = 1'b0;
            state_in  = ST_RESP;
            if (!status.command) begin
               cmd.push = status.sample_ok;
            end else if (status.status_ok) begin
               if (!status.pps_present) begin
                  report_in = RPT_ACQUIRING;
                  phase_in  = PH_WAIT_PPS;
               end else begin
                  case (phase_ff)
                     PH_WAIT_PPS: begin
                        report_in = RPT_ACQUIRED;
                        meas_in   = 1'b1;
                        lim_in    = 1'b1;
                        phase_in  = PH_SETTLE;
                     end
                     PH_SETTLE: begin
                        if (status.pps_below) begin
                           report_in     = RPT_DISCIPLINED;
                           cmd.clear_win = 1'b1;
                           phase_in      = PH_SET_TIME;
                        end else begin
                           report_in = RPT_DISCIPLINING;
                        end
                     end
                     PH_SET_TIME: begin
                        if (!status.win_full) begin
                           report_in = RPT_SYNCHRONIZING;
                        end else if (status.win_empty) begin
                           report_in = RPT_SYNCED;
                           done_in   = 1'b1;
                           lim_in    = 1'b1;
                           phase_in  = PH_MONITOR;
                        end else begin
                           cmd.init_search = 1'b1;
                           state_in        = ST_LOAD_I;
                        end
                     end
                     default: begin
                        report_in = RPT_MONITORING;
                     end
                  endcase
               end
            end
         end
         ST_LOAD_I: begin
            state_in = ST_GET_I;
         end
         ST_GET_I: begin
            cmd.get_i = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd = 1'b1;
            if (status.outer_last) begin
               state_in = ST_VERDICT;
            end else begin
               state_in = ST_LOAD_I;
            end
         end
         ST_VERDICT: begin
            if (status.best_zero) begin
               report_in = RPT_SYNCED;
               done_in   = 1'b1;
               lim_in    = 1'b1;
               phase_in  = PH_MONITOR;
            end else begin
               report_in     = RPT_ADJUSTING;
               adj_in        = 1'b1;
               cmd.clear_win = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_search_in_set_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_UPDATE) |-> (phase_ff == PH_SET_TIME))
      else $error("mode search outside set-time phase");

   a_done_is_synced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (report_ff == RPT_SYNCED && phase_ff == PH_MONITOR))
      else $error("sync done without synced report");

   a_monitor_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MONITOR && $past(phase_ff) != PH_MONITOR)
         |-> ($past(phase_ff) == PH_SET_TIME))
      else $error("monitor entered from wrong phase");
`endif

endmodule

@@ rtl/pps_gps_clock_sync_supervisor.sv @@
// pps_gps_clock_sync_supervisor: top level joining pgcs_ctrl and pgcs_dp, depends on pgcs_pkg
// flow: request registered on acceptance, decided in ST_DECIDE, loaded into the response
//   register from ST_RESP once free; a set-time tick with a full window also runs the
//   single-port mode search; throughput: one transaction at a time
// reset: synchronous; phase, window fill and head, config registers to defaults;
//   window contents are not cleared

module pps_gps_clock_sync_supervisor #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pgcs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pgcs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pgcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pgcs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pgcs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   pgcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pgcs_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
